// ===== design/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// Types and codes shared by the id-indexed list insert block and its checker.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int ID_W = 10;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] athlete_id;
    logic [ID_W-1:0] anchor_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] out_id;
    logic            last;
    logic [1:0]      status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_LOOK_B,
    S_WR_MID,
    S_WR_TAIL,
    S_FIN
  } state_t;

endpackage

// ===== design/idll_ram.sv =====
// ----------------------------------------------------------------------------
// idll_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/id_indexed_list_insert_before.sv =====
// ----------------------------------------------------------------------------
// id_indexed_list_insert_before
// Ordered line of ids kept as a doubly linked list in two RAMs: one holds
// {present, next} per id, the other holds prev per id.
//
//   channel | ports                     | direction
//   input   | in_valid in_stall in_data  | insert or read command in
//   output  | out_valid out_stall out_data | one result per command out
//
// a read passes S_LOOK and S_FIN; an insert of a new id adds S_LOOK_B,
// then S_WR_MID or S_WR_TAIL if it needs two link writes, set by the one
// read port of the {present, next} RAM; after reset a clearing pass walks
// min(ID_COUNT, 1024) presence RAM entries; in_stall stays high meanwhile
// results sit in an output register; a new item is taken while it waits,
// and a finished result waits in its own state until that register is free
// ----------------------------------------------------------------------------
module id_indexed_list_insert_before #(
  parameter int ID_COUNT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  idll_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output idll_pkg::out_item_t out_data
);

  import idll_pkg::*;

  localparam int DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] to_addr(logic [ID_W-1:0] id);
    return id[AW-1:0];
  endfunction

  function automatic logic id_ok(logic [ID_W-1:0] id);
    return 32'(id) < 32'(DEPTH);
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  in_item_t        item_r, item_nxt;
  logic [ID_W-1:0] head_r, head_nxt;
  logic [ID_W-1:0] tail_r, tail_nxt;
  logic [ID_W-1:0] cursor_r, cursor_nxt;
  logic            empty_r, empty_nxt;
  logic [ID_W-1:0] prev_b_r, prev_b_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r;
  out_item_t       out_data_r;
  logic            out_free;
  logic            hit;

  logic            a_we;
  logic [AW-1:0]   a_waddr, a_raddr;
  logic [ID_W:0]   a_wdata, a_rdata;
  logic            b_we;
  logic [AW-1:0]   b_waddr, b_raddr;
  logic [ID_W-1:0] b_wdata, b_rdata;

  idll_ram #(.WIDTH(ID_W + 1), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  idll_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    item_nxt   = item_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cursor_nxt = cursor_r;
    empty_nxt  = empty_r;
    prev_b_nxt = prev_b_r;
    res_nxt    = res_r;
    in_stall   = 1'b1;
    hit        = 1'b0;
    a_we       = 1'b0;
    a_waddr    = to_addr(item_r.athlete_id);
    a_wdata    = '0;
    // reads issued straight from the input in the accepting cycle
    a_raddr    = to_addr((in_data.command == CMD_READ) ? cursor_r : in_data.athlete_id);
    b_we       = 1'b0;
    b_waddr    = to_addr(item_r.anchor_id);
    b_wdata    = item_r.athlete_id;
    b_raddr    = to_addr(in_data.anchor_id);

    case (state_r)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        prev_b_nxt = b_rdata;
        state_nxt  = S_FIN;
        if (item_r.command == CMD_READ) begin
          if (empty_r) begin
            res_nxt = '{out_id: '0, last: 1'b0, status: STAT_EMPTY};
          end else begin
            res_nxt = '{out_id: cursor_r, last: (cursor_r == tail_r), status: STAT_OK};
            cursor_nxt = (cursor_r == tail_r) ? head_r : a_rdata[ID_W-1:0];
          end
        end else if (!id_ok(item_r.athlete_id) || a_rdata[ID_W]) begin
          res_nxt    = '{out_id: '0, last: 1'b0, status: STAT_DUP};
          cursor_nxt = head_r;
        end else begin
          a_raddr   = to_addr(item_r.anchor_id);
          state_nxt = S_LOOK_B;
        end
      end
      S_LOOK_B: begin
        res_nxt = '{out_id: '0, last: 1'b0, status: STAT_OK};
        hit     = !empty_r && id_ok(item_r.anchor_id) && a_rdata[ID_W];
        if (hit && item_r.anchor_id == head_r) begin
          a_we       = 1'b1;
          a_wdata    = {1'b1, item_r.anchor_id};
          b_we       = 1'b1;
          head_nxt   = item_r.athlete_id;
          cursor_nxt = item_r.athlete_id;
          state_nxt  = S_FIN;
        end else if (hit) begin
          // next of the old predecessor, prev of the new id
          a_we      = 1'b1;
          a_waddr   = to_addr(prev_b_r);
          a_wdata   = {1'b1, item_r.athlete_id};
          b_we      = 1'b1;
          b_waddr   = to_addr(item_r.athlete_id);
          b_wdata   = prev_b_r;
          state_nxt = S_WR_MID;
        end else if (empty_r) begin
          a_we       = 1'b1;
          a_wdata    = {1'b1, {ID_W{1'b0}}};
          head_nxt   = item_r.athlete_id;
          tail_nxt   = item_r.athlete_id;
          empty_nxt  = 1'b0;
          cursor_nxt = item_r.athlete_id;
          state_nxt  = S_FIN;
        end else begin
          a_we      = 1'b1;
          a_waddr   = to_addr(tail_r);
          a_wdata   = {1'b1, item_r.athlete_id};
          b_we      = 1'b1;
          b_waddr   = to_addr(item_r.athlete_id);
          b_wdata   = tail_r;
          state_nxt = S_WR_TAIL;
        end
      end
      S_WR_MID: begin
        a_we       = 1'b1;
        a_wdata    = {1'b1, item_r.anchor_id};
        b_we       = 1'b1;
        cursor_nxt = head_r;
        state_nxt  = S_FIN;
      end
      S_WR_TAIL: begin
        a_we       = 1'b1;
        a_wdata    = {1'b1, {ID_W{1'b0}}};
        tail_nxt   = item_r.athlete_id;
        cursor_nxt = head_r;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cursor_r    <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cursor_r <= cursor_nxt;
      empty_r  <= empty_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    prev_b_r <= prev_b_nxt;
    res_r    <= res_nxt;
    if (state_r == S_FIN && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/idll_checker.sv =====
// ----------------------------------------------------------------------------
// idll_checker
// Port-level checks for the id-indexed list insert block.
// ----------------------------------------------------------------------------
module idll_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input idll_pkg::out_item_t out_data
);

  import idll_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the clearing pass keeps the input closed right after reset
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during clearing pass");

  // one item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is at work");

  // error results carry no id and no last flag (insert results also carry no id)
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.out_id == '0 && !out_data.last)
    else $error("error result with nonzero id or last");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == STAT_OK || out_data.status == STAT_DUP ||
                  out_data.status == STAT_EMPTY)
    else $error("undefined status code");

endmodule

bind id_indexed_list_insert_before idll_checker u_idll_checker (.*);
